@@ hdl/b64sc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package b64sc_pkg;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_PLUS    = 8'd43;
    localparam logic [7:0] CHAR_SLASH   = 8'd47;
    localparam logic [7:0] CODE_UPPER_LIMIT = 8'd91;
    localparam logic [7:0] CODE_DIGIT_LIMIT = 8'd58;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_PLUS       = 6'd62;
    localparam logic [5:0] SEXTET_SLASH      = 6'd63;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } res_pair_t;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] c;
        priority if (v < SEXTET_LOWER_BASE) begin
            c = {2'b00, v} + CHAR_UPPER_A;
        end else if (v < SEXTET_DIGIT_BASE) begin
            c = {2'b00, v} - {2'b00, SEXTET_LOWER_BASE} + CHAR_LOWER_A;
        end else if (v < SEXTET_PLUS) begin
            c = {2'b00, v} - {2'b00, SEXTET_DIGIT_BASE} + CHAR_ZERO;
        end else if (v == SEXTET_PLUS) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] v;
        priority if (c == CHAR_SLASH) begin
            v = {2'b00, SEXTET_SLASH};
        end else if (c == CHAR_PLUS) begin
            v = {2'b00, SEXTET_PLUS};
        end else if (c < CODE_DIGIT_LIMIT) begin
            v = c - CHAR_ZERO + {2'b00, SEXTET_DIGIT_BASE};
        end else if (c < CODE_UPPER_LIMIT) begin
            v = c - CHAR_UPPER_A;
        end else begin
            v = c - CHAR_LOWER_A + {2'b00, SEXTET_LOWER_BASE};
        end
        return v[5:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/base64_stream_codec_unit.sv @@
// base64_stream_codec_unit: streaming base64 encoder/decoder, no padding
// cfg_we/cfg_wdata select the direction (0 encode, 1 decode); a write also
// drops any partial group, so write only while the block is idle
// s_ channel: one byte or character per transfer, stream_end marks the last
// item of a stream; m_ channel: one byte or character per transfer, run_last
// marks the final result produced by an input item
// encode gives one or two characters per byte (the partial group is flushed
// zero-filled on stream_end); decode gives zero or one byte per character
// a result is offered in the cycle after its input transfer
// throughput: one item per cycle while m_ready is high and each item yields at
// most one result; an item yielding two holds off the next (one result port)
// a two-entry result register decouples the sides, so the next item is taken
// in the cycle the last pending result leaves
// when m_ready is low results hold steady and s_ready drops once a new item
// would overrun the result register
// reset (aresetn low, synchronous) empties the result register, clears the
// bit accumulator and selects encode
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_codec_unit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire b64sc_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output b64sc_pkg::out_item_t      m_data
);
    import b64sc_pkg::*;

    logic      item_fire;
    res_pair_t res;

    assign item_fire = s_valid && s_ready;

    b64sc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_fire (item_fire),
        .item      (s_data),
        .res       (res)
    );

    b64sc_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (item_fire),
        .res        (res),
        .load_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

@@ hdl/b64sc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module b64sc_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,
    input  wire logic                 item_fire,
    input  wire b64sc_pkg::in_item_t  item,
    output b64sc_pkg::res_pair_t      res
);
    import b64sc_pkg::*;

    logic       direction_reg;
    logic [7:0] pend_bits_reg, pend_bits_next;
    logic [2:0] pend_cnt_reg, pend_cnt_next;

    logic [3:0]  n;
    logic [3:0]  n_left;
    logic [11:0] acc;
    logic [11:0] acc_left;

    function automatic logic [11:0] low_mask(input logic [3:0] bits);
        return (12'd1 << bits) - 12'd1;
    endfunction

    always_comb begin
        res.count       = 2'd0;
        res.first_byte  = 8'd0;
        res.second_byte = 8'd0;
        n               = 4'd0;
        n_left          = 4'd0;
        acc             = 12'd0;
        acc_left        = 12'd0;
        if (direction_reg == DIR_ENCODE) begin
            n   = (pend_cnt_reg > 3'd4) ? 4'd4 : {1'b0, pend_cnt_reg};
            acc = ((({4'b0, pend_bits_reg}) & low_mask(n)) << 8) | {4'b0, item.in_byte};
            n_left         = n + 4'd2;
            res.first_byte = sextet_to_char(6'(acc >> n_left));
            res.count      = 2'd1;
            if (n_left >= 4'd6) begin
                res.second_byte = sextet_to_char(6'(acc >> (n_left - 4'd6)));
                res.count       = 2'd2;
                n_left          = n_left - 4'd6;
            end
            acc_left = acc & low_mask(n_left);
            if (item.stream_end && n_left != 4'd0 && res.count == 2'd1) begin
                res.second_byte = sextet_to_char(6'(acc_left << (4'd6 - n_left)));
                res.count       = 2'd2;
                n_left          = 4'd0;
                acc_left        = 12'd0;
            end
        end else begin
            n   = (pend_cnt_reg > 3'd6) ? 4'd6 : {1'b0, pend_cnt_reg};
            acc = ((({4'b0, pend_bits_reg}) & low_mask(n)) << 6)
                  | {6'b0, char_to_sextet(item.in_byte)};
            n_left = n + 4'd6;
            if (n_left >= 4'd8) begin
                res.first_byte = 8'(acc >> (n_left - 4'd8));
                res.count      = 2'd1;
                n_left         = n_left - 4'd8;
            end
            acc_left = acc & low_mask(n_left);
        end
    end

    always_comb begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (cfg_we) begin
            pend_bits_next = 8'd0;
            pend_cnt_next  = 3'd0;
        end else if (item_fire) begin
            if (item.stream_end) begin
                pend_bits_next = 8'd0;
                pend_cnt_next  = 3'd0;
            end else begin
                pend_bits_next = acc_left[7:0];
                pend_cnt_next  = n_left[2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DIR_ENCODE;
            pend_bits_reg <= 8'd0;
            pend_cnt_reg  <= 3'd0;
        end else begin
            if (cfg_we) begin
                direction_reg <= cfg_wdata;
            end
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/b64sc_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module b64sc_out_buf (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire b64sc_pkg::res_pair_t res,
    output logic                      load_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output b64sc_pkg::out_item_t      m_data
);
    import b64sc_pkg::*;

    logic [1:0] rem_reg, rem_next;
    logic [7:0] slot0_reg, slot0_next;
    logic [7:0] slot1_reg, slot1_next;

    // slot1 always holds the final result of an item
    assign m_valid         = (rem_reg != 2'd0);
    assign m_data.out_byte = (rem_reg == 2'd2) ? slot0_reg : slot1_reg;
    assign m_data.run_last = (rem_reg == 2'd1);
    assign load_ready      = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_ready);

    always_comb begin
        rem_next   = rem_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load) begin
            rem_next = res.count;
            if (res.count == 2'd2) begin
                slot0_next = res.first_byte;
                slot1_next = res.second_byte;
            end else begin
                slot1_next = res.first_byte;
            end
        end else if (m_valid && m_ready) begin
            rem_next = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire
